// ----- rtl/core/plsm_pkg.sv -----
// ----------------------------------------------------------------------------
// Per-layer slot map package
// Shared widths, payload structs and codes of the per-layer LRU slot map.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package plsm_pkg;

  localparam int SLOTS       = 16;
  localparam int LAYERS      = 64;
  localparam int EXPERT_BITS = 12;
  localparam int STAMP_W     = 32;
  localparam int SLOT_W      = $clog2(SLOTS);
  localparam int SLOT_CW     = $clog2(SLOTS + 2);
  localparam int LAYER_W     = $clog2(LAYERS);
  localparam int LAYER_CW    = $clog2(LAYERS + 1);
  localparam int CFG_W       = 7;

  typedef enum logic [1:0] {
    FUNC_REQUEST = 2'd0,
    FUNC_COMMIT  = 2'd1,
    FUNC_FLUSH   = 2'd2,
    FUNC_NONE    = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_BAD_LAYER = 2'd1,
    STAT_TOO_LONG  = 2'd2,
    STAT_NO_VICTIM = 2'd3
  } status_t;

  typedef enum logic {
    REG_SLOTS_IN_USE  = 1'b0,
    REG_LAYERS_IN_USE = 1'b1
  } reg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_COMMIT,
    ST_HIT,
    ST_MISS,
    ST_SCAN,
    ST_PICK,
    ST_WB,
    ST_EMIT,
    ST_ACK
  } state_t;

  typedef struct packed {
    logic [1:0]             func;
    logic [5:0]             layer_number;
    logic [11:0]            expert_number;
    logic                   batch_end;
    logic [3:0]             fill_slot;
    logic                   fill_ok;
  } in_item_t;

  typedef struct packed {
    logic [3:0]             position;
    logic [3:0]             slot;
    logic                   is_hit;
    logic [11:0]            missed_expert;
    logic [4:0]             miss_total;
    logic [1:0]             status;
    logic                   last;
  } out_item_t;

  typedef struct packed {
    logic [STAMP_W-1:0]                       clk;
    logic [SLOTS-1:0]                         vld;
    logic [SLOTS-1:0][EXPERT_BITS-1:0]        exp;
  } owner_row_t;

  typedef logic [SLOTS-1:0][STAMP_W-1:0] stamp_row_t;

endpackage

`default_nettype wire

// ----- rtl/core/per_layer_slot_lru_map.sv -----
// ----------------------------------------------------------------------------
// Per-layer slot LRU map
// Maps expert ids to slots per layer; rows of owners and stamps are held in
// two synchronous memories and processed by a sequencer.
// ----------------------------------------------------------------------------
// Sequencing: a commit acknowledgement is registered after the load, commit and
// write-back states; a batch is answered after its final transfer through load,
// hit lookup, a victim scan per miss and write-back, then one result per cycle
// while the output is not stalled. One item at a time; request elements before
// the end stay in idle, flushes and error acknowledgements go straight to ack.
// Reset is synchronous: every row reads as empty with zero stamps and clocks.
`timescale 1ns / 1ps
`default_nettype none

module per_layer_slot_lru_map (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  plsm_pkg::in_item_t     in_item,
  output logic                   out_valid,
  input  wire                    out_ready,
  output plsm_pkg::out_item_t    out_item,
  input  wire                    cfg_valid,
  output logic                   cfg_ready,
  input  wire                    cfg_index,
  input  wire [plsm_pkg::CFG_W-1:0] cfg_data
);
  import plsm_pkg::*;

  owner_row_t own_mem [LAYERS];
  stamp_row_t rec_mem [LAYERS];
  owner_row_t own_q_r;
  stamp_row_t rec_q_r;

  state_t state_r, state_nxt;
  logic [SLOT_CW-1:0]  slots_r, cnt_r, k_r, cnt_new, misses_r;
  logic [LAYER_CW-1:0] layers_r;
  logic [LAYER_W-1:0]  blayer_r, cur_r, layer_eff, rd_addr;
  logic [EXPERT_BITS-1:0] bexp_r [SLOTS];
  logic [SLOT_W-1:0]   slot_of_r [SLOTS];
  logic [LAYERS-1:0]   own_ok_r, rec_ok_r;
  logic [SLOT_W-1:0]   cfs_r, i_r, s_r, empty_idx_r, best_idx_r, hit_idx;
  logic [EXPERT_BITS-1:0] cexp_r;
  logic                cok_r, commit_r, ack_r, empty_r, best_r, hit_found;
  logic [STAMP_W-1:0]  best_age_r, clk_inc;
  logic [SLOTS-1:0]    guard_r, claim_r, hit_r, match;
  owner_row_t          row_r;
  stamp_row_t          rec_r;
  out_item_t           pend_r, out_r;
  logic                out_valid_r, ofree, acc, mem_we, out_load, i_last, s_last;

  assign acc       = in_valid && in_ready;
  assign ofree     = !out_valid_r || out_ready;
  assign cnt_new   = (cnt_r < SLOT_CW'(SLOTS + 1)) ? cnt_r + 1'b1 : cnt_r;
  assign layer_eff = (cnt_r == '0) ? in_item.layer_number : blayer_r;
  assign clk_inc   = (row_r.clk == '1) ? row_r.clk : row_r.clk + 1'b1;
  assign i_last    = ({1'b0, i_r} == k_r - 1'b1);
  assign s_last    = ({1'b0, s_r} == slots_r - 1'b1);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;
  assign cfg_ready = 1'b1;

  always_comb begin
    match     = '0;
    hit_idx   = '0;
    hit_found = 1'b0;
    for (int s = 0; s < SLOTS; s++) begin
      match[s] = (SLOT_CW'(s) < slots_r) && row_r.vld[s] && (row_r.exp[s] == bexp_r[i_r]);
    end
    for (int s = SLOTS - 1; s >= 0; s--) begin
      if (match[s]) begin
        hit_idx   = SLOT_W'(s);
        hit_found = 1'b1;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          case (in_item.func)
            FUNC_REQUEST: begin
              if (in_item.batch_end) begin
                if ({1'b0, layer_eff} >= layers_r || cnt_new > slots_r) begin
                  state_nxt = ST_ACK;
                end else begin
                  state_nxt = ST_LOAD;
                end
              end
            end
            FUNC_COMMIT: begin
              if ({1'b0, in_item.layer_number} >= layers_r
                  || {1'b0, in_item.fill_slot} >= slots_r) begin
                state_nxt = ST_ACK;
              end else begin
                state_nxt = ST_LOAD;
              end
            end
            FUNC_FLUSH: state_nxt = ST_ACK;
            default:    state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_LOAD:   state_nxt = commit_r ? ST_COMMIT : ST_HIT;
      ST_COMMIT: state_nxt = ST_WB;
      ST_HIT:    state_nxt = i_last ? ST_MISS : ST_HIT;
      ST_MISS: begin
        if (!hit_r[i_r]) begin
          state_nxt = ST_SCAN;
        end else if (i_last) begin
          state_nxt = ST_WB;
        end
      end
      ST_SCAN: state_nxt = s_last ? ST_PICK : ST_SCAN;
      ST_PICK: begin
        if ((!empty_r && !best_r) || i_last) begin
          state_nxt = ST_WB;
        end else begin
          state_nxt = ST_MISS;
        end
      end
      ST_WB:   state_nxt = ack_r ? ST_ACK : ST_EMIT;
      ST_EMIT: state_nxt = (ofree && i_last) ? ST_IDLE : ST_EMIT;
      ST_ACK:  state_nxt = ofree ? ST_IDLE : ST_ACK;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state_r == ST_IDLE);
    mem_we   = (state_r == ST_WB);
    out_load = ofree && (state_r == ST_EMIT || state_r == ST_ACK);
    rd_addr  = cur_r;
    if (state_r == ST_IDLE) begin
      rd_addr = (in_item.func == FUNC_COMMIT) ? in_item.layer_number : layer_eff;
    end
  end

  always_ff @(posedge clk) begin
    own_q_r <= own_mem[rd_addr];
    rec_q_r <= rec_mem[rd_addr];
    if (mem_we) begin
      own_mem[cur_r] <= row_r;
      rec_mem[cur_r] <= rec_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      slots_r     <= SLOT_CW'(SLOTS);
      layers_r    <= LAYER_CW'(LAYERS);
      cnt_r       <= '0;
      blayer_r    <= '0;
      own_ok_r    <= '0;
      rec_ok_r    <= '0;
      out_valid_r <= 1'b0;
      guard_r     <= '0;
      claim_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (acc) begin
            pend_r <= '0;
            pend_r.last <= 1'b1;
            case (in_item.func)
              FUNC_REQUEST: begin
                if (cnt_r == '0) begin
                  blayer_r <= in_item.layer_number;
                end
                if (cnt_r < SLOT_CW'(SLOTS)) begin
                  bexp_r[cnt_r[SLOT_W-1:0]] <= in_item.expert_number;
                end
                cnt_r    <= cnt_new;
                k_r      <= cnt_new;
                cur_r    <= layer_eff;
                commit_r <= 1'b0;
                if (in_item.batch_end) begin
                  cnt_r <= '0;
                  if ({1'b0, layer_eff} >= layers_r) begin
                    pend_r.status <= STAT_BAD_LAYER;
                  end else if (cnt_new > slots_r) begin
                    pend_r.status <= STAT_TOO_LONG;
                  end
                end
              end
              FUNC_COMMIT: begin
                pend_r.slot          <= in_item.fill_slot;
                pend_r.missed_expert <= in_item.expert_number;
                cur_r    <= in_item.layer_number;
                cfs_r    <= in_item.fill_slot;
                cexp_r   <= in_item.expert_number;
                cok_r    <= in_item.fill_ok;
                commit_r <= 1'b1;
                if ({1'b0, in_item.layer_number} >= layers_r) begin
                  pend_r.status <= STAT_BAD_LAYER;
                end else if ({1'b0, in_item.fill_slot} >= slots_r) begin
                  pend_r.status <= STAT_NO_VICTIM;
                end
              end
              FUNC_FLUSH: own_ok_r <= '0;
              default: ;
            endcase
          end
        end
        ST_LOAD: begin
          row_r    <= own_ok_r[cur_r] ? own_q_r : '0;
          rec_r    <= rec_ok_r[cur_r] ? rec_q_r : '0;
          i_r      <= '0;
          misses_r <= '0;
          guard_r  <= '0;
          claim_r  <= '0;
          hit_r    <= '0;
          ack_r    <= commit_r;
        end
        ST_COMMIT: begin
          if (cok_r) begin
            row_r.vld[cfs_r] <= 1'b1;
            row_r.exp[cfs_r] <= cexp_r;
            row_r.clk        <= clk_inc;
            rec_r[cfs_r]     <= clk_inc;
          end
        end
        ST_HIT: begin
          if (hit_found) begin
            hit_r[i_r]     <= 1'b1;
            guard_r[hit_idx] <= 1'b1;
            slot_of_r[i_r] <= hit_idx;
            row_r.clk      <= clk_inc;
            rec_r[hit_idx] <= clk_inc;
          end else begin
            misses_r <= misses_r + 1'b1;
          end
          i_r <= i_last ? '0 : i_r + 1'b1;
        end
        ST_MISS: begin
          s_r     <= '0;
          empty_r <= 1'b0;
          best_r  <= 1'b0;
          if (hit_r[i_r] && !i_last) begin
            i_r <= i_r + 1'b1;
          end
        end
        ST_SCAN: begin
          if (!claim_r[s_r] && !row_r.vld[s_r] && !empty_r) begin
            empty_r     <= 1'b1;
            empty_idx_r <= s_r;
          end
          if (!claim_r[s_r] && !guard_r[s_r] && (!best_r || rec_r[s_r] < best_age_r)) begin
            best_r     <= 1'b1;
            best_idx_r <= s_r;
            best_age_r <= rec_r[s_r];
          end
          s_r <= s_r + 1'b1;
        end
        ST_PICK: begin
          if (empty_r) begin
            claim_r[empty_idx_r] <= 1'b1;
            slot_of_r[i_r]       <= empty_idx_r;
          end else if (best_r) begin
            claim_r[best_idx_r]  <= 1'b1;
            slot_of_r[i_r]       <= best_idx_r;
          end else begin
            ack_r              <= 1'b1;
            pend_r.status      <= STAT_NO_VICTIM;
            pend_r.miss_total  <= misses_r;
          end
          if (!i_last) begin
            i_r <= i_r + 1'b1;
          end
        end
        ST_WB: begin
          own_ok_r[cur_r] <= 1'b1;
          rec_ok_r[cur_r] <= 1'b1;
          i_r             <= '0;
        end
        ST_EMIT: begin
          if (ofree) begin
            out_r.position      <= i_r;
            out_r.slot          <= slot_of_r[i_r];
            out_r.is_hit        <= hit_r[i_r];
            out_r.missed_expert <= hit_r[i_r] ? '0 : bexp_r[i_r];
            out_r.miss_total    <= misses_r;
            out_r.status        <= STAT_OK;
            out_r.last          <= i_last;
            i_r                 <= i_r + 1'b1;
          end
        end
        ST_ACK: begin
          if (ofree) begin
            out_r <= pend_r;
          end
        end
        default: ;
      endcase
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_SLOTS_IN_USE) begin
          if (cfg_data != '0 && cfg_data <= CFG_W'(SLOTS)) begin
            slots_r  <= SLOT_CW'(cfg_data);
            own_ok_r <= '0;
            rec_ok_r <= '0;
            cnt_r    <= '0;
          end
        end else begin
          if (cfg_data != '0 && cfg_data <= CFG_W'(LAYERS)) begin
            layers_r <= LAYER_CW'(cfg_data);
          end
        end
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= SLOT_CW'(SLOTS + 1))
    else $error("batch count beyond saturation");

  a_claim_guard: assert property (@(posedge clk) disable iff (!rst_n)
    (claim_r & guard_r) == '0)
    else $error("a protected slot was claimed");

  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.status == STAT_OK |-> {1'b0, out_r.slot} < slots_r)
    else $error("result slot outside the bank");

  a_emit_after_wb: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == ST_EMIT) |-> $past(state_r) == ST_WB)
    else $error("results emitted before write-back");

endmodule

`default_nettype wire
